[src/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge while out of reset
`define TSD_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tsd assertion failed");

// checked on every rising edge, reset included
`define TSD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("tsd assertion failed during reset");

`endif

[src/tsd_pkg.sv]
package tsd_pkg;

  // telnet protocol bytes
  localparam logic [7:0] IAC  = 8'd255;
  localparam logic [7:0] SE   = 8'd240;
  localparam logic [7:0] SB   = 8'd250;
  localparam logic [7:0] WILL = 8'd251;
  localparam logic [7:0] WONT = 8'd252;
  localparam logic [7:0] DO   = 8'd253;
  localparam logic [7:0] DONT = 8'd254;

  // result kinds
  localparam logic [2:0] KIND_DATA    = 3'd0;
  localparam logic [2:0] KIND_CMD     = 3'd1;
  localparam logic [2:0] KIND_NEG     = 3'd2;
  localparam logic [2:0] KIND_SB_DATA = 3'd3;
  localparam logic [2:0] KIND_SB_END  = 3'd4;

  // default depth of the result queue
  localparam int unsigned RES_FIFO_DEPTH = 4;

  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] verb;
    logic [7:0] option;
    logic [7:0] value;
    logic       last;
  } res_t;

endpackage

[src/telnet_stream_deframer_unit.sv]
// channel | signals                                   | direction
// --------+-------------------------------------------+----------
// input   | in_valid_i, in_ready_o, in_byte_i          | in
// output  | out_valid_o, out_ready_i, kind_o, verb_o,  | out
//         | option_o, value_o, last_o                  |
//
// one byte is taken per cycle while the result queue has room for two items
// each byte is parsed in the cycle it is taken and its results enter the queue
// the queue head is presented directly from storage, with no output register
// a stalled output only blocks input once the queue has fewer than two free slots
// reset clears the parse phase, held verb and option, and empties the queue
`include "assert_macros.svh"

module telnet_stream_deframer_unit #(
  parameter int unsigned Depth = tsd_pkg::RES_FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] kind_o,
  output logic [1:0] verb_o,
  output logic [7:0] option_o,
  output logic [7:0] value_o,
  output logic       last_o
);
  import tsd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  // parse phases
  localparam logic [2:0] PH_DATA   = 3'd0;
  localparam logic [2:0] PH_IAC    = 3'd1;
  localparam logic [2:0] PH_NEGOPT = 3'd2;
  localparam logic [2:0] PH_SBOPT  = 3'd3;
  localparam logic [2:0] PH_SBDATA = 3'd4;
  localparam logic [2:0] PH_SBIAC  = 3'd5;

  logic [2:0] phase_q, phase_d;
  logic [1:0] verb_q, verb_d;
  logic [7:0] opt_q, opt_d;

  res_t       res0, res1;
  logic [1:0] n_res;

  res_t            fifo_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q, wr_ptr1, wr_ptr2, rd_ptr_nxt;
  logic [CntW-1:0] count_q, count_d;

  logic acc, pop;

  // room for the worst case of two results
  assign in_ready_o = (count_q <= CntW'(Depth - 2));
  assign acc        = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign pop        = out_valid_o && out_ready_i;

  // byte parser
  always_comb begin
    phase_d = phase_q;
    verb_d  = verb_q;
    opt_d   = opt_q;
    n_res   = 2'd0;
    res0    = '0;
    res1    = '0;
    case (phase_q)
      PH_IAC: begin
        if (in_byte_i inside {[WILL:DONT]}) begin
          verb_d  = 2'(in_byte_i - WILL);
          phase_d = PH_NEGOPT;
        end else if (in_byte_i == SB) begin
          phase_d = PH_SBOPT;
        end else begin
          phase_d    = PH_DATA;
          n_res      = 2'd1;
          res0.kind  = KIND_CMD;
          res0.value = in_byte_i;
          res0.last  = 1'b1;
        end
      end
      PH_NEGOPT: begin
        phase_d     = PH_DATA;
        n_res       = 2'd1;
        res0.kind   = KIND_NEG;
        res0.verb   = verb_q;
        res0.option = in_byte_i;
        res0.last   = 1'b1;
      end
      PH_SBOPT: begin
        opt_d   = in_byte_i;
        phase_d = PH_SBDATA;
      end
      PH_SBDATA: begin
        if (in_byte_i == IAC) begin
          phase_d = PH_SBIAC;
        end else begin
          n_res       = 2'd1;
          res0.kind   = KIND_SB_DATA;
          res0.option = opt_q;
          res0.value  = in_byte_i;
          res0.last   = 1'b1;
        end
      end
      PH_SBIAC: begin
        if (in_byte_i == SE) begin
          phase_d     = PH_DATA;
          n_res       = 2'd1;
          res0.kind   = KIND_SB_END;
          res0.option = opt_q;
          res0.last   = 1'b1;
        end else begin
          // escaped byte: both bytes go out raw as payload
          phase_d     = PH_SBDATA;
          n_res       = 2'd2;
          res0.kind   = KIND_SB_DATA;
          res0.option = opt_q;
          res0.value  = IAC;
          res1.kind   = KIND_SB_DATA;
          res1.option = opt_q;
          res1.value  = in_byte_i;
          res1.last   = 1'b1;
        end
      end
      default: begin
        // plain data, unused codes included
        if (in_byte_i == IAC) begin
          phase_d = PH_IAC;
        end else begin
          phase_d    = PH_DATA;
          n_res      = 2'd1;
          res0.kind  = KIND_DATA;
          res0.value = in_byte_i;
          res0.last  = 1'b1;
        end
      end
    endcase
  end

  // queue pointers with wrap at any depth
  assign wr_ptr1    = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
  assign wr_ptr2    = (wr_ptr1 == PtrW'(Depth - 1)) ? '0 : wr_ptr1 + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;

  always_comb begin
    count_d = count_q - CntW'(pop);
    if (acc) begin
      count_d = count_d + CntW'(n_res);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_DATA;
      verb_q   <= '0;
      opt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (acc) begin
        phase_q <= phase_d;
        verb_q  <= verb_d;
        opt_q   <= opt_d;
        if (n_res == 2'd1) begin
          wr_ptr_q <= wr_ptr1;
        end else if (n_res == 2'd2) begin
          wr_ptr_q <= wr_ptr2;
        end
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_nxt;
      end
      count_q <= count_d;
    end
  end

  // queue storage, payload only
  always_ff @(posedge clk_i) begin
    if (acc && (n_res != 2'd0)) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (acc && (n_res == 2'd2)) begin
      fifo_q[wr_ptr1] <= res1;
    end
  end

  assign kind_o   = fifo_q[rd_ptr_q].kind;
  assign verb_o   = fifo_q[rd_ptr_q].verb;
  assign option_o = fifo_q[rd_ptr_q].option;
  assign value_o  = fifo_q[rd_ptr_q].value;
  assign last_o   = fifo_q[rd_ptr_q].last;

  `TSD_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(Depth))
  `TSD_ASSERT(a_escape_pair, clk_i, rst_ni,
    (acc && phase_q == PH_SBIAC && in_byte_i != SE) |=>
      ((count_q + CntW'($past(pop))) == ($past(count_q) + CntW'(2))))
  `TSD_ASSERT(a_pair_whole, clk_i, rst_ni,
    (out_valid_o && !last_o) |-> (count_q >= CntW'(2)))
  `TSD_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> (count_q == '0))

endmodule
